FILE: rtl/deci_pkg.sv
// ----------------------------------------------------------------------------
// deci_pkg: shared types for the display escape command interpreter
// Parse modes, action codes, command match codes and the structs that
// travel between the parser and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package deci_pkg;

  // number of configuration registers and width of their index
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLEEP       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SELECT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COMMANDS    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RESET_PULSE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DATA_BLOCK  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PIN         = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_END         = 3'd7;

  // register reset values
  localparam logic [7:0] RST_ESCAPE      = 8'd27;
  localparam logic [7:0] RST_SLEEP       = 8'd1;
  localparam logic [7:0] RST_SELECT      = 8'd2;
  localparam logic [7:0] RST_COMMANDS    = 8'd3;
  localparam logic [7:0] RST_RESET_PULSE = 8'd4;
  localparam logic [7:0] RST_DATA_BLOCK  = 8'd5;
  localparam logic [7:0] RST_PIN         = 8'd6;
  localparam logic [7:0] RST_END         = 8'd7;

  // reset pulse sequence: reset 1, delay, reset 0, delay, reset 1
  localparam int PULSE_IDX_W = 3;
  localparam logic [PULSE_IDX_W-1:0] PULSE_LOW_IDX  = 3'd2;
  localparam logic [PULSE_IDX_W-1:0] PULSE_LAST_IDX = 3'd4;

  // output tdata layout
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [3:0] {
    MODE_SCAN      = 4'd0,
    MODE_CODE      = 4'd1,
    MODE_SLEEP     = 4'd2,
    MODE_SELECT    = 4'd3,
    MODE_RESET     = 4'd4,
    MODE_LENGTH    = 4'd5,
    MODE_BLOCK     = 4'd6,
    MODE_PIN_NUM   = 4'd7,
    MODE_PIN_LEVEL = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    ACT_DATA   = 3'd0,
    ACT_SELECT = 3'd1,
    ACT_DC     = 3'd2,
    ACT_RESET  = 3'd3,
    ACT_PIN    = 3'd4,
    ACT_DELAY  = 3'd5,
    ACT_END    = 3'd6,
    ACT_ERROR  = 3'd7
  } act_t;

  // which command a code byte matches, in priority order
  typedef enum logic [3:0] {
    CMD_SLEEP,
    CMD_SELECT,
    CMD_COMMANDS,
    CMD_RESET_PULSE,
    CMD_DATA_BLOCK,
    CMD_PIN,
    CMD_END,
    CMD_ESCAPE,
    CMD_UNKNOWN
  } cmd_t;

  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] sleep_code;
    logic [7:0] select_code;
    logic [7:0] commands_code;
    logic [7:0] reset_pulse_code;
    logic [7:0] data_block_code;
    logic [7:0] pin_code;
    logic [7:0] end_code;
  } cfg_t;

  // results caused by one input byte
  typedef struct packed {
    logic       has;     // at least one result
    logic       pulse;   // five-result reset pulse sequence
    act_t       action;
    logic [7:0] value;   // for a pulse: the delay in ms
    logic [7:0] pin;
  } grp_t;

endpackage

`default_nettype wire

FILE: rtl/deci_parser.sv
// ----------------------------------------------------------------------------
// deci_parser: command stream parser
// Decodes one stream byte per cycle while in_ready is high, against the
// parse state, and registers the group of results it causes for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module deci_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           in_byte,
  input  deci_pkg::cfg_t       cfg,
  input  wire                  emit_free,  // emitter can load a group now
  output logic                 grp_valid,
  output deci_pkg::grp_t       grp
);

  deci_pkg::mode_t parse_mode, parse_mode_next;
  logic [7:0]      bytes_left, bytes_left_next;
  logic [7:0]      held_pin, held_pin_next;
  logic [7:0]      left_dec;
  deci_pkg::cmd_t  cmd;
  deci_pkg::grp_t  grp_next;
  logic            accept;
  logic            grp_move;

  // group register drains when empty-handed or when the emitter takes it
  assign grp_move = grp_valid && (!grp.has || emit_free);
  assign in_ready = !grp_valid || grp_move;
  assign accept   = in_valid && in_ready;

  // command code match, first hit wins
  always_comb begin
    if (in_byte == cfg.sleep_code) begin
      cmd = deci_pkg::CMD_SLEEP;
    end else if (in_byte == cfg.select_code) begin
      cmd = deci_pkg::CMD_SELECT;
    end else if (in_byte == cfg.commands_code) begin
      cmd = deci_pkg::CMD_COMMANDS;
    end else if (in_byte == cfg.reset_pulse_code) begin
      cmd = deci_pkg::CMD_RESET_PULSE;
    end else if (in_byte == cfg.data_block_code) begin
      cmd = deci_pkg::CMD_DATA_BLOCK;
    end else if (in_byte == cfg.pin_code) begin
      cmd = deci_pkg::CMD_PIN;
    end else if (in_byte == cfg.end_code) begin
      cmd = deci_pkg::CMD_END;
    end else if (in_byte == cfg.escape_code) begin
      cmd = deci_pkg::CMD_ESCAPE;
    end else begin
      cmd = deci_pkg::CMD_UNKNOWN;
    end
  end

  assign left_dec = (bytes_left != 8'd0) ? bytes_left - 8'd1 : bytes_left;

  // next parse state
  always_comb begin
    parse_mode_next = deci_pkg::MODE_SCAN;
    bytes_left_next = bytes_left;
    held_pin_next   = held_pin;
    case (parse_mode)
      deci_pkg::MODE_SCAN: begin
        if (in_byte == cfg.escape_code) begin
          parse_mode_next = deci_pkg::MODE_CODE;
        end
      end
      deci_pkg::MODE_CODE: begin
        case (cmd)
          deci_pkg::CMD_SLEEP:       parse_mode_next = deci_pkg::MODE_SLEEP;
          deci_pkg::CMD_SELECT:      parse_mode_next = deci_pkg::MODE_SELECT;
          deci_pkg::CMD_RESET_PULSE: parse_mode_next = deci_pkg::MODE_RESET;
          deci_pkg::CMD_DATA_BLOCK:  parse_mode_next = deci_pkg::MODE_LENGTH;
          deci_pkg::CMD_PIN:         parse_mode_next = deci_pkg::MODE_PIN_NUM;
          default:                   parse_mode_next = deci_pkg::MODE_SCAN;
        endcase
      end
      deci_pkg::MODE_LENGTH: begin
        bytes_left_next = in_byte;
        if (in_byte != 8'd0) begin
          parse_mode_next = deci_pkg::MODE_BLOCK;
        end
      end
      deci_pkg::MODE_BLOCK: begin
        bytes_left_next = left_dec;
        if (left_dec != 8'd0) begin
          parse_mode_next = deci_pkg::MODE_BLOCK;
        end
      end
      deci_pkg::MODE_PIN_NUM: begin
        held_pin_next   = in_byte;
        parse_mode_next = deci_pkg::MODE_PIN_LEVEL;
      end
      default: parse_mode_next = deci_pkg::MODE_SCAN;
    endcase
  end

  // results for this byte
  always_comb begin
    grp_next.has    = 1'b0;
    grp_next.pulse  = 1'b0;
    grp_next.action = deci_pkg::ACT_DATA;
    grp_next.value  = in_byte;
    grp_next.pin    = 8'd0;
    case (parse_mode)
      deci_pkg::MODE_SCAN: begin
        grp_next.has = (in_byte != cfg.escape_code);
      end
      deci_pkg::MODE_CODE: begin
        case (cmd)
          deci_pkg::CMD_COMMANDS: begin
            grp_next.has    = 1'b1;
            grp_next.action = deci_pkg::ACT_DC;
            grp_next.value  = 8'd0;
          end
          deci_pkg::CMD_END: begin
            grp_next.has    = 1'b1;
            grp_next.action = deci_pkg::ACT_END;
            grp_next.value  = 8'd0;
          end
          deci_pkg::CMD_ESCAPE: begin
            grp_next.has    = 1'b1;
            grp_next.action = deci_pkg::ACT_DATA;
          end
          deci_pkg::CMD_UNKNOWN: begin
            grp_next.has    = 1'b1;
            grp_next.action = deci_pkg::ACT_ERROR;
          end
          default: grp_next.has = 1'b0;
        endcase
      end
      deci_pkg::MODE_SLEEP: begin
        grp_next.has    = 1'b1;
        grp_next.action = deci_pkg::ACT_DELAY;
      end
      deci_pkg::MODE_SELECT: begin
        grp_next.has    = 1'b1;
        grp_next.action = deci_pkg::ACT_SELECT;
        grp_next.value  = {7'd0, in_byte == 8'd0};
      end
      deci_pkg::MODE_RESET: begin
        grp_next.has    = 1'b1;
        grp_next.pulse  = 1'b1;
        grp_next.action = deci_pkg::ACT_RESET;
      end
      deci_pkg::MODE_LENGTH: begin
        grp_next.has    = 1'b1;
        grp_next.action = deci_pkg::ACT_DC;
        grp_next.value  = 8'd1;
      end
      deci_pkg::MODE_BLOCK: begin
        grp_next.has    = 1'b1;
      end
      deci_pkg::MODE_PIN_LEVEL: begin
        grp_next.has    = 1'b1;
        grp_next.action = deci_pkg::ACT_PIN;
        grp_next.value  = {7'd0, in_byte != 8'd0};
        grp_next.pin    = held_pin;
      end
      default: grp_next.has = 1'b0;
    endcase
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= deci_pkg::MODE_SCAN;
      bytes_left <= 8'd0;
      held_pin   <= 8'd0;
    end else if (accept) begin
      parse_mode <= parse_mode_next;
      bytes_left <= bytes_left_next;
      held_pin   <= held_pin_next;
    end
  end

  // result group register
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (accept) begin
      grp_valid <= 1'b1;
    end else if (grp_move) begin
      grp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp <= grp_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/deci_emitter.sv
// ----------------------------------------------------------------------------
// deci_emitter: result output register
// Holds one result group and sends its results one per transaction; a
// reset pulse group steps through its five results with a small counter.
// ----------------------------------------------------------------------------
`default_nettype none

module deci_emitter (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         load,      // take grp this cycle
  input  deci_pkg::grp_t              grp,
  output logic                        free,      // a load is taken now
  output logic                        out_valid,
  input  wire                         out_ready,
  output deci_pkg::act_t              out_action,
  output logic [7:0]                  out_value,
  output logic [7:0]                  out_pin,
  output logic                        out_last
);

  deci_pkg::grp_t                        cur;
  logic [deci_pkg::PULSE_IDX_W-1:0]      idx;
  logic                                  xfer;

  assign xfer = out_valid && out_ready;
  assign free = !out_valid || (xfer && out_last);

  // result fields for the current position in the group
  always_comb begin
    out_action = cur.action;
    out_value  = cur.value;
    out_pin    = cur.pin;
    out_last   = 1'b1;
    if (cur.pulse) begin
      out_last = (idx == deci_pkg::PULSE_LAST_IDX);
      if (idx[0]) begin
        out_action = deci_pkg::ACT_DELAY;
      end else begin
        out_action = deci_pkg::ACT_RESET;
        out_value  = {7'd0, idx != deci_pkg::PULSE_LOW_IDX};
      end
    end
  end

  // valid flag and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (xfer) begin
      if (out_last) begin
        out_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= grp;
    end
  end

`ifndef SYNTHESIS
  // counter stays within the pulse sequence
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx <= deci_pkg::PULSE_LAST_IDX))
    else $error("pulse index out of range");

  // single-result groups never advance the counter
  a_idx_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cur.pulse) |-> (idx == '0))
    else $error("counter moved on single result");

  // a non-final transaction steps to the next result of the group
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (xfer && !out_last && !load) |=> (out_valid && idx == $past(idx) + 1'b1))
    else $error("pulse sequence did not advance");

  // the final transaction empties the register unless a group is loaded
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (xfer && out_last && !load) |=> !out_valid)
    else $error("result repeated after last");
`endif

endmodule

`default_nettype wire

FILE: rtl/display_escape_command_interpreter.sv
// ----------------------------------------------------------------------------
// display_escape_command_interpreter: escape-coded display command decoder
// Configuration registers, the parser stage and the result emitter.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while s_tready is high and turns it into
// display actions. A byte is decoded in the cycle it is accepted; its results
// are registered in the parser stage and then in the output register. Every
// byte gives at most one result and, while the output is ready, streams at
// one byte per cycle, except the argument of a reset pulse command: its five
// results leave the output register one per transaction, so the input stalls
// behind them. While a result waits in the output register the parser
// stage still takes bytes, until the next byte that causes a result is held
// there. The user must write command codes through the configuration port
// only while the stream is idle; the block itself does not enforce this.
`default_nettype none

module display_escape_command_interpreter (
  input  wire        clk,
  input  wire        rst,
  // stream input
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] stream_byte
  // result output
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [deci_pkg::OUT_TDATA_W-1:0] m_tdata, // [2:0] action, [10:3] value,
                                                   // [18:11] pin_number, rest 0
  output logic       m_tlast,
  // configuration
  input  wire        cfg_we,
  input  wire  [deci_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire  [7:0] cfg_data
);

  deci_pkg::cfg_t cfg;
  deci_pkg::grp_t grp;
  deci_pkg::act_t out_action;
  logic           grp_valid;
  logic           emit_free;
  logic [7:0]     out_value;
  logic [7:0]     out_pin;

  // command code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_code      <= deci_pkg::RST_ESCAPE;
      cfg.sleep_code       <= deci_pkg::RST_SLEEP;
      cfg.select_code      <= deci_pkg::RST_SELECT;
      cfg.commands_code    <= deci_pkg::RST_COMMANDS;
      cfg.reset_pulse_code <= deci_pkg::RST_RESET_PULSE;
      cfg.data_block_code  <= deci_pkg::RST_DATA_BLOCK;
      cfg.pin_code         <= deci_pkg::RST_PIN;
      cfg.end_code         <= deci_pkg::RST_END;
    end else if (cfg_we) begin
      case (cfg_index)
        deci_pkg::REG_ESCAPE:      cfg.escape_code      <= cfg_data;
        deci_pkg::REG_SLEEP:       cfg.sleep_code       <= cfg_data;
        deci_pkg::REG_SELECT:      cfg.select_code      <= cfg_data;
        deci_pkg::REG_COMMANDS:    cfg.commands_code    <= cfg_data;
        deci_pkg::REG_RESET_PULSE: cfg.reset_pulse_code <= cfg_data;
        deci_pkg::REG_DATA_BLOCK:  cfg.data_block_code  <= cfg_data;
        deci_pkg::REG_PIN:         cfg.pin_code         <= cfg_data;
        deci_pkg::REG_END:         cfg.end_code         <= cfg_data;
        default: ;
      endcase
    end
  end

  deci_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .cfg       (cfg),
    .emit_free (emit_free),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  deci_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (grp_valid && grp.has && emit_free),
    .grp        (grp),
    .free       (emit_free),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_action (out_action),
    .out_value  (out_value),
    .out_pin    (out_pin),
    .out_last   (m_tlast)
  );

  // pack result fields, lowest first
  assign m_tdata = {5'd0, out_pin, out_value, out_action};

endmodule

`default_nettype wire
